[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet while rst_n low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/ldpc_rm_pkg.sv]
// ---------------------------------------------------------------------------
// ldpc_rm_pkg
// Types, constants and tables shared by the LDPC rate matcher modules.
// ---------------------------------------------------------------------------
package ldpc_rm_pkg;

    localparam int DEF_MAX_CODEWORD = 32768;
    localparam int DEF_MAX_OUTPUT   = 32768;

    localparam int N_W       = 16;  // N = 66 * 511 fits
    localparam int Z_W       = 9;
    localparam int Q_W       = 4;
    localparam int SHIFT_W   = 6;
    localparam int DIV_W     = SHIFT_W + N_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [N_W-1:0] BG1_COLS = N_W'(66);
    localparam logic [N_W-1:0] BG2_COLS = N_W'(50);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SELECT = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_GRAPH   = 3'd0,
        REG_LIFTING_SIZE = 3'd1,
        REG_RV           = 3'd2,
        REG_BPS          = 3'd3,
        REG_LBUF_LEN     = 3'd4,
        REG_OUT_LEN      = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic select;
        logic read_go;
        logic div_k0;
        logic prep_scan;
        logic scan;
        logic scan_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic scan_done;
        logic read_ok;
        logic out_free;
    } status_t;

    function automatic logic [SHIFT_W-1:0] shift_of(input logic bg, input logic [1:0] rv);
        logic [SHIFT_W-1:0] s;
        begin
            s = '0;
            unique case ({bg, rv})
                3'b000: s = 6'd0;
                3'b001: s = 6'd17;
                3'b010: s = 6'd33;
                3'b011: s = 6'd56;
                3'b100: s = 6'd0;
                3'b101: s = 6'd13;
                3'b110: s = 6'd25;
                3'b111: s = 6'd43;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

endpackage

[sv/ldpc_rm_if.sv]
// ---------------------------------------------------------------------------
// ldpc_rm_if
// Valid/ready channels for input words and result words.
// ---------------------------------------------------------------------------
interface ldpc_rm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       bit_value;
    logic       is_filler;

    modport source (output valid, output kind, output bit_value, output is_filler,
                    input ready);
    modport sink   (input valid, input kind, input bit_value, input is_filler,
                    output ready);
endinterface

interface ldpc_rm_out_if;
    logic valid;
    logic ready;
    logic out_bit;
    logic last;
    logic error;

    modport source (output valid, output out_bit, output last, output error,
                    input ready);
    modport sink   (input valid, input out_bit, input last, input error,
                    output ready);
endinterface

[sv/ldpc_rate_matcher_unit.sv]
// ---------------------------------------------------------------------------
// ldpc_rate_matcher_unit
// NR LDPC rate matching: bit selection from a circular buffer and bit
// interleaving, over a codeword loaded one bit per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries a kind code with each word: load appends one codeword bit
//   with its filler mark, select runs bit selection, read asks for the next
//   interleaved output bit. Load words go in one per cycle when idle; a read
//   holds the input until its word is loaded into the output register.
//   out_ch returns one word per read: the bit, a last mark on bit E-1 and the
//   all-filler error. Reads past E give no word.
//   A read registers the selected bit, then loads it into the output register.
//   A select runs two 22-step divisions on the divider, k0 and E/Q, with their
//   hand-offs, then scans the circular buffer, one codeword memory read per
//   position, until E bits are stored, or until a full pass finds only filler
//   bits.
//   in_ch.ready is low while a select or a pending read is in progress.
//   If out_ch stalls, the pending read holds until the output word is taken.
//   Configuration is written through cfg_we/cfg_index/cfg_data, by the user
//   only while idle, which the block does not enforce. Reset clears the control
//   state and the registers to their defaults; memories are not cleared.
// ---------------------------------------------------------------------------
module ldpc_rate_matcher_unit #(
    parameter int MAX_CODEWORD = ldpc_rm_pkg::DEF_MAX_CODEWORD,
    parameter int MAX_OUTPUT   = ldpc_rm_pkg::DEF_MAX_OUTPUT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ldpc_rm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldpc_rm_pkg::CFG_W-1:0]     cfg_data,
    ldpc_rm_in_if.sink                        in_ch,
    ldpc_rm_out_if.source                     out_ch
);
    import ldpc_rm_pkg::*;

    cmd_t    cmd;
    status_t status;

    ldpc_rm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ldpc_rm_dp #(
        .MAX_CODEWORD (MAX_CODEWORD),
        .MAX_OUTPUT   (MAX_OUTPUT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_bit_value (in_ch.bit_value),
        .in_is_filler (in_ch.is_filler),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_bit      (out_ch.out_bit),
        .out_last     (out_ch.last),
        .out_error    (out_ch.error)
    );

endmodule

[sv/ldpc_rm_ctrl.sv]
// ---------------------------------------------------------------------------
// ldpc_rm_ctrl
// Sequencer: accepts words, steps the selection run and the output hand-off.
// ---------------------------------------------------------------------------
module ldpc_rm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_kind,
    output logic                 in_ready,
    input  ldpc_rm_pkg::status_t status,
    output ldpc_rm_pkg::cmd_t    cmd
);
    import ldpc_rm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_DIVK = 7'b0000100,
        ST_MULK = 7'b0001000,
        ST_DIVE = 7'b0010000,
        ST_SCAN = 7'b0100000,
        ST_RDW  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    kind_t  kind;

    assign kind     = kind_t'(in_kind);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_LOAD: cmd.load = 1'b1;
                        KIND_SELECT:
                        begin
                            cmd.select = 1'b1;
                            state_next = ST_PREP;
                        end
                        KIND_READ:
                        begin
                            if (status.read_ok)
                            begin
                                cmd.read_go = 1'b1;
                                state_next  = ST_RDW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP:
            begin
                cmd.div_k0 = 1'b1;
                state_next = ST_DIVK;
            end
            ST_DIVK:
            begin
                if (!status.div_busy)
                    state_next = ST_MULK;
            end
            ST_MULK:
            begin
                cmd.prep_scan = 1'b1;
                state_next    = ST_DIVE;
            end
            ST_DIVE:
            begin
                if (!status.div_busy)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                    cmd.scan = 1'b1;
            end
            ST_RDW:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/ldpc_rm_dp.sv]
// ---------------------------------------------------------------------------
// ldpc_rm_dp
// Datapath: registers, codeword and selection memories, bit-serial divider,
// circular scan and interleaver address counters, output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ldpc_rm_dp #(
    parameter int MAX_CODEWORD = ldpc_rm_pkg::DEF_MAX_CODEWORD,
    parameter int MAX_OUTPUT   = ldpc_rm_pkg::DEF_MAX_OUTPUT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ldpc_rm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ldpc_rm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                  in_bit_value,
    input  logic                                  in_is_filler,
    input  ldpc_rm_pkg::cmd_t                     cmd,
    output ldpc_rm_pkg::status_t                  status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  out_bit,
    output logic                                  out_last,
    output logic                                  out_error
);
    import ldpc_rm_pkg::*;

    localparam int CW_AW  = $clog2(MAX_CODEWORD);
    localparam int CNT_W  = CW_AW + 1;
    localparam int OUT_AW = $clog2(MAX_OUTPUT);
    localparam int E_W    = OUT_AW + 1;
    localparam int QT_W   = E_W + 1;
    localparam logic [N_W:0]   MAXC_X  = (N_W+1)'(MAX_CODEWORD);
    localparam logic [N_W-1:0] MAXC    = N_W'(MAX_CODEWORD);
    localparam logic [CNT_W-1:0] MAXC_CNT = CNT_W'(MAX_CODEWORD);
    localparam logic [16:0]    MAXO_X  = 17'(MAX_OUTPUT);

    // configuration
    logic             bg_reg;
    logic [Z_W-1:0]   z_cfg_reg;
    logic [1:0]       rv_reg;
    logic [Q_W-1:0]   bps_reg;
    logic [14:0]      lbl_reg;
    logic [15:0]      olen_reg;

    // selection run
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     ncb_reg;
    logic [Z_W-1:0]     z_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [E_W-1:0]     e_reg;
    logic [Q_W-1:0]     q_reg;
    logic [CNT_W-1:0]   lc_reg;
    logic [N_W-1:0]     pos_reg;
    logic [N_W-1:0]     steps_reg;
    logic [E_W-1:0]     j_reg;
    logic               found_reg;
    logic               rd_vld_reg;
    logic               flag_reg;
    logic [1:0]         cw_q_reg;

    // divider
    logic [DIV_W-1:0]     dnum_reg;
    logic [N_W-1:0]       ddiv_reg;
    logic [N_W-1:0]       drem_reg;
    logic [DIV_W-1:0]     dquo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 dbusy_reg;

    // interleaver
    logic [E_W-1:0]  rd_idx_reg;
    logic [Q_W-1:0]  h_reg;
    logic [E_W-1:0]  col_reg;
    logic [QT_W-1:0] quot_reg;
    logic [Q_W-1:0]  remi_reg;
    logic            last_pend_reg;
    logic            sel_q_reg;

    logic            out_valid_reg;
    logic            out_bit_reg;
    logic            out_last_reg;
    logic            out_error_reg;

    logic [1:0] cw_mem  [MAX_CODEWORD];
    logic       sel_mem [MAX_OUTPUT];

    // combinational
    logic [N_W-1:0]         n_calc;
    logic [N_W-1:0]         lbl_x;
    logic [N_W-1:0]         ncb_a;
    logic [N_W-1:0]         ncb_calc;
    logic [E_W-1:0]         e_calc;
    logic [DIV_W-1:0]       prod_k0;
    logic [SHIFT_W+Z_W-1:0] k0;
    logic [N_W:0]           trial;
    logic                   ge;
    logic [N_W:0]           diff;
    logic [E_W-1:0]         eq;
    logic [Q_W-1:0]         er;
    logic [Q_W:0]           rsum;
    logic                   rcarry;
    logic [E_W-1:0]         src;
    logic                   scan_take;
    logic                   scan_wr;
    logic [N_W-1:0]         pos_inc;

    assign n_calc   = {{(N_W-Z_W){1'b0}}, z_cfg_reg} * (bg_reg ? BG2_COLS : BG1_COLS);
    assign lbl_x    = {1'b0, lbl_reg};
    assign ncb_a    = (lbl_reg == '0 || lbl_x > n_calc) ? n_calc : lbl_x;
    assign ncb_calc = ({1'b0, ncb_a} > MAXC_X) ? MAXC : ncb_a;
    assign e_calc   = ({1'b0, olen_reg} > MAXO_X) ? E_W'(MAX_OUTPUT) : E_W'(olen_reg);

    assign prod_k0 = {{(DIV_W-SHIFT_W){1'b0}}, shift_reg} * {{(DIV_W-N_W){1'b0}}, ncb_reg};
    assign k0      = {{Z_W{1'b0}}, dquo_reg[SHIFT_W-1:0]} * {{SHIFT_W{1'b0}}, z_reg};

    assign trial = {drem_reg, dnum_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, ddiv_reg});
    assign diff  = trial - {1'b0, ddiv_reg};

    assign eq     = dquo_reg[E_W-1:0];
    assign er     = drem_reg[Q_W-1:0];
    assign rsum   = {1'b0, remi_reg} + {1'b0, er};
    assign rcarry = (rsum >= {1'b0, q_reg});
    assign src    = (quot_reg >= {1'b0, e_reg}) ? (e_reg - 1'b1) : quot_reg[E_W-1:0];

    assign scan_take = cmd.scan && rd_vld_reg;
    assign scan_wr   = scan_take && !cw_q_reg[1] && (j_reg < e_reg);
    assign pos_inc   = (pos_reg + 1'b1 == ncb_reg) ? '0 : pos_reg + 1'b1;

    assign status.div_busy  = dbusy_reg;
    assign status.scan_done = (j_reg == e_reg) || (steps_reg == ncb_reg && !found_reg);
    assign status.read_ok   = (rd_idx_reg < e_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg    <= 1'b0;
            z_cfg_reg <= Z_W'(384);
            rv_reg    <= '0;
            bps_reg   <= Q_W'(2);
            lbl_reg   <= '0;
            olen_reg  <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_BASE_GRAPH:   bg_reg    <= cfg_data[0];
                REG_LIFTING_SIZE: z_cfg_reg <= cfg_data[Z_W-1:0];
                REG_RV:           rv_reg    <= cfg_data[1:0];
                REG_BPS:          bps_reg   <= cfg_data[Q_W-1:0];
                REG_LBUF_LEN:     lbl_reg   <= cfg_data[14:0];
                REG_OUT_LEN:      olen_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // latch the run parameters on select
    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            n_reg     <= n_calc;
            ncb_reg   <= ncb_calc;
            z_reg     <= z_cfg_reg;
            shift_reg <= shift_of(bg_reg, rv_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg      <= '0;
            q_reg      <= Q_W'(1);
            lc_reg     <= '0;
            rd_idx_reg <= '0;
            h_reg      <= '0;
            col_reg    <= '0;
            quot_reg   <= '0;
            remi_reg   <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.select)
            begin
                e_reg      <= e_calc;
                q_reg      <= (bps_reg == '0) ? Q_W'(1) : bps_reg;
                lc_reg     <= '0;
                rd_idx_reg <= '0;
                h_reg      <= '0;
                col_reg    <= '0;
                quot_reg   <= '0;
                remi_reg   <= '0;
            end
            else if (cmd.load && lc_reg < MAXC_CNT)
                lc_reg <= lc_reg + 1'b1;
            else if (cmd.read_go)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (h_reg == q_reg - 1'b1)
                begin
                    // column wraps: source restarts at the new column index
                    h_reg    <= '0;
                    col_reg  <= col_reg + 1'b1;
                    quot_reg <= {1'b0, col_reg + 1'b1};
                    remi_reg <= '0;
                end
                else
                begin
                    h_reg    <= h_reg + 1'b1;
                    quot_reg <= quot_reg + {1'b0, eq} + {{(QT_W-1){1'b0}}, rcarry};
                    remi_reg <= rcarry ? Q_W'(rsum - {1'b0, q_reg}) : rsum[Q_W-1:0];
                end
            end
            if (cmd.scan_end)
                flag_reg <= !found_reg;
        end
    end

    // bit-serial restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_k0 || cmd.prep_scan)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DIV_CNT_W'(DIV_W - 1);
        end
        else if (dbusy_reg)
        begin
            if (dcnt_reg == '0)
                dbusy_reg <= 1'b0;
            else
                dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_k0)
        begin
            dnum_reg <= prod_k0;
            ddiv_reg <= n_reg;
            drem_reg <= '0;
            dquo_reg <= '0;
        end
        else if (cmd.prep_scan)
        begin
            dnum_reg <= {{(DIV_W-E_W){1'b0}}, e_reg};
            ddiv_reg <= {{(N_W-Q_W){1'b0}}, q_reg};
            drem_reg <= '0;
            dquo_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            dnum_reg <= {dnum_reg[DIV_W-2:0], 1'b0};
            drem_reg <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
            dquo_reg <= {dquo_reg[DIV_W-2:0], ge};
        end
    end

    // circular scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg      <= '0;
            steps_reg  <= '0;
            found_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.prep_scan)
        begin
            j_reg      <= '0;
            steps_reg  <= '0;
            found_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (scan_take)
                steps_reg <= steps_reg + 1'b1;
            if (scan_wr)
            begin
                j_reg     <= j_reg + 1'b1;
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep_scan)
            pos_reg <= {{(N_W-SHIFT_W-Z_W){1'b0}}, k0};
        else if (cmd.scan)
            pos_reg <= pos_inc;
    end

    // codeword memory: load writes, scan reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && lc_reg < MAXC_CNT)
            cw_mem[lc_reg[CW_AW-1:0]] <= {in_is_filler, in_bit_value};
        if (cmd.scan)
            cw_q_reg <= cw_mem[pos_reg[CW_AW-1:0]];
    end

    // selection memory: scan writes, reads fetch in interleaver order
    always_ff @(posedge clk)
    begin
        if (scan_wr)
            sel_mem[j_reg[OUT_AW-1:0]] <= cw_q_reg[0];
        if (cmd.read_go)
        begin
            sel_q_reg     <= sel_mem[src[OUT_AW-1:0]];
            last_pend_reg <= (rd_idx_reg == e_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_bit_reg   <= sel_q_reg & !flag_reg;
            out_last_reg  <= last_pend_reg;
            out_error_reg <= flag_reg;
        end
    end

    `ASSERT_IMP(a_read_index_bound, 1'b1, rd_idx_reg <= e_reg)
    `ASSERT_IMP(a_scan_fill_bound, cmd.scan, j_reg <= e_reg)
    `ASSERT_IMP(a_interleave_rem, 1'b1, remi_reg < q_reg && h_reg < q_reg)

endmodule

[test/ldpc_rm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ldpc_rm_checker
// Watches the configuration port and both channels of the rate matcher,
// predicts every result word from the accepted input words and compares.
// ---------------------------------------------------------------------------
module ldpc_rm_checker
    import ldpc_rm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    ldpc_rm_in_if                in_ch,
    ldpc_rm_out_if               out_ch,
    output int                   fails,
    output int                   pending
);

    typedef struct packed {
        logic out_bit;
        logic last;
        logic error;
    } rm_word_t;

    localparam int CW_DEPTH  = DEF_MAX_CODEWORD;
    localparam int OUT_DEPTH = DEF_MAX_OUTPUT;

    logic [0:0]  bg_r;
    logic [8:0]  z_r;
    logic [1:0]  rv_r;
    logic [3:0]  q_r;
    logic [14:0] lbl_r;
    logic [15:0] e_r;

    logic [1:0] codeword[CW_DEPTH];
    logic       selected[OUT_DEPTH];
    logic       gathered[CW_DEPTH];
    int unsigned load_cnt, rd_idx, sel_e, sel_q;
    logic        all_filler;

    rm_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic int unsigned start_shift(logic bg, logic [1:0] rv);
        case ({bg, rv})
            3'b001:  return 17;
            3'b010:  return 33;
            3'b011:  return 56;
            3'b101:  return 13;
            3'b110:  return 25;
            3'b111:  return 43;
            default: return 0;
        endcase
    endfunction

    task automatic run_selection();
        int unsigned n, ncb, e, k0, pos, cnt, k;
        n   = (bg_r ? 50 : 66) * z_r;
        ncb = lbl_r;
        e   = e_r;
        cnt = 0;
        if (ncb == 0 || ncb > n) ncb = n;
        if (ncb > CW_DEPTH) ncb = CW_DEPTH;
        if (e > OUT_DEPTH) e = OUT_DEPTH;
        if (ncb > 0)
        begin
            k0  = ((start_shift(bg_r, rv_r) * ncb) / n) * z_r;
            pos = k0 % ncb;
            for (int j = 0; j < ncb; j++)
            begin
                if (!codeword[pos][1])
                begin
                    gathered[cnt] = codeword[pos][0];
                    cnt++;
                end
                pos++;
                if (pos == ncb) pos = 0;
            end
        end
        all_filler = (cnt == 0);
        k = 0;
        for (int j = 0; j < e; j++)
        begin
            if (cnt == 0)
                selected[j] = 1'b0;
            else
            begin
                selected[j] = gathered[k];
                k++;
                if (k == cnt) k = 0;
            end
        end
        sel_e    = e;
        sel_q    = (q_r == 0) ? 1 : q_r;
        load_cnt = 0;
        rd_idx   = 0;
    endtask

    task automatic predict_read();
        int unsigned h, src;
        rm_word_t w;
        if (rd_idx >= sel_e) return;
        h   = rd_idx % sel_q;
        src = (rd_idx + h * (sel_e - 1)) / sel_q;
        if (src >= sel_e) src = sel_e - 1;
        w.out_bit = selected[src];
        w.last    = (rd_idx == sel_e - 1);
        w.error   = all_filler;
        expected_words.push_back(w);
        rd_idx++;
    endtask

    initial
    begin
        fails = 0;
        for (int j = 0; j < CW_DEPTH; j++) codeword[j] = 2'b00;
    end

    always @(posedge clk or negedge rst_n)
    begin
        rm_word_t w;
        if (!rst_n)
        begin
            bg_r       = 1'b0;
            z_r        = 9'd384;
            rv_r       = 2'd0;
            q_r        = 4'd2;
            lbl_r      = '0;
            e_r        = 16'd1;
            load_cnt   = 0;
            rd_idx     = 0;
            sel_e      = 0;
            sel_q      = 1;
            all_filler = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_BASE_GRAPH:   bg_r  = cfg_data[0];
                    REG_LIFTING_SIZE: z_r   = cfg_data[8:0];
                    REG_RV:           rv_r  = cfg_data[1:0];
                    REG_BPS:          q_r   = cfg_data[3:0];
                    REG_LBUF_LEN:     lbl_r = cfg_data[14:0];
                    REG_OUT_LEN:      e_r   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (kind_t'(in_ch.kind))
                    KIND_LOAD:
                        if (load_cnt < CW_DEPTH)
                        begin
                            codeword[load_cnt] = {in_ch.is_filler, in_ch.bit_value};
                            load_cnt++;
                        end
                    KIND_SELECT: run_selection();
                    KIND_READ:   predict_read();
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with none expected");
                    fails++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (out_ch.out_bit !== w.out_bit)
                    begin
                        $error("out_bit: expected %0d, got %0d", w.out_bit, out_ch.out_bit);
                        fails++;
                    end
                    if (out_ch.last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, out_ch.last);
                        fails++;
                    end
                    if (out_ch.error !== w.error)
                    begin
                        $error("error: expected %0d, got %0d", w.error, out_ch.error);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Rate matcher testbench: loads codewords, runs selections over many
// settings and reads the interleaved bits back under random back-pressure.
// ---------------------------------------------------------------------------
module tb;
    import ldpc_rm_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fails;
    int                   pending;
    bit                   quiet;
    bit                   stall_req;
    int                   items;

    ldpc_rm_in_if  in_ch();
    ldpc_rm_out_if out_ch();

    ldpc_rate_matcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    ldpc_rm_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                stall_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 11);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(0, 19);
                repeat (n) @(negedge clk);
            end
        end
    end

    task automatic send_word(kind_t k, logic b, logic f);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.bit_value <= b;
        in_ch.is_filler <= f;
        do @(posedge clk); while (!in_ch.ready);
        items++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // hold until every word is back and the block takes input again
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_W-1:0];
        @(negedge clk);
    endtask

    // fill: 0 sparse filler, 1 all filler, 2 no filler
    task automatic run_codeword(int bg, int z, int rv, int q, int lbl, int e,
                                int fill, int extra, int reads, bit noise);
        int unsigned n, ncb;
        logic f;
        wait_idle();
        write_reg(REG_BASE_GRAPH, bg);
        write_reg(REG_LIFTING_SIZE, z);
        write_reg(REG_RV, rv);
        write_reg(REG_BPS, q);
        write_reg(REG_LBUF_LEN, lbl);
        write_reg(REG_OUT_LEN, e);
        cfg_we <= 1'b0;
        n   = (bg ? 50 : 66) * z;
        ncb = (lbl == 0 || lbl > n) ? n : lbl;
        if (ncb > DEF_MAX_CODEWORD) ncb = DEF_MAX_CODEWORD;
        for (int j = 0; j < ncb + extra; j++)
        begin
            f = (fill == 1) ? 1'b1 : (fill == 2) ? 1'b0 : ($urandom_range(0, 9) == 0);
            send_word(KIND_LOAD, 1'($urandom_range(0, 1)), f);
            if (noise && $urandom_range(0, 15) == 0)
                send_word(KIND_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        send_word(KIND_SELECT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int j = 0; j < reads; j++)
        begin
            send_word(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (noise && $urandom_range(0, 15) == 0)
                send_word(KIND_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int z_pick[16] = '{2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 384};
        int bg, z, q, e, lbl, reads, fill;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_LOAD;
        in_ch.bit_value = 1'b0;
        in_ch.is_filler = 1'b0;
        quiet           = 1'b0;
        stall_req       = 1'b0;
        items           = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reads before any selection and an unknown kind give nothing
        send_word(KIND_READ, 1'b1, 1'b1);
        send_word(KIND_NONE, 1'b1, 1'b0);
        send_word(KIND_READ, 1'b0, 1'b0);

        run_codeword(0, 2, 0, 1, 0, 20, 0, 0, 22, 1'b1);
        run_codeword(1, 2, 3, 8, 25344, 40, 0, 2, 41, 1'b0);
        run_codeword(0, 384, 2, 6, 200, 36, 0, 0, 36, 1'b0);
        run_codeword(1, 3, 1, 2, 0, 8, 1, 0, 9, 1'b0);
        run_codeword(0, 4, 3, 4, 50, 32768, 2, 0, 20, 1'b0);
        run_codeword(1, 2, 2, 3, 1, 7, 0, 0, 8, 1'b0);

        // fill the block while the result side holds off
        stall_req = 1'b1;
        run_codeword(0, 2, 1, 2, 0, 60, 0, 0, 60, 1'b0);

        while (items < 1200)
        begin
            bg  = $urandom_range(0, 1);
            z   = ($urandom_range(0, 19) == 0) ? 384 : z_pick[$urandom_range(0, 6)];
            q   = $urandom_range(1, 8);
            e   = q * $urandom_range(1, 40);
            if ($urandom_range(0, 5) == 0) e = $urandom_range(1, 300);
            lbl = ($urandom_range(0, 2) == 0) ? 0 :
                  $urandom_range(1, (bg ? 50 : 66) * ((z > 16) ? 3 : z) + 20);
            if (z > 16 && lbl == 0) lbl = $urandom_range(1, 250);
            reads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, e) : e + $urandom_range(0, 2);
            fill  = ($urandom_range(0, 19) == 0) ? 1 : 0;
            run_codeword(bg, z, $urandom_range(0, 3), q, lbl, e, fill,
                         $urandom_range(0, 3), reads, 1'($urandom_range(0, 1)));
        end

        // last codeword with no idling on either side
        quiet = 1'b1;
        run_codeword(0, 2, 1, 2, 0, 64, 0, 3, 66, 1'b0);

        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[ldpc_rate_matcher_unit.f]
+incdir+sv
sv/ldpc_rm_pkg.sv
sv/ldpc_rm_if.sv
sv/ldpc_rm_ctrl.sv
sv/ldpc_rm_dp.sv
sv/ldpc_rate_matcher_unit.sv
test/ldpc_rm_checker.sv
test/tb.sv
